FILE: hdl/interval_reservation_table_macros.svh
// Assertion macros for the interval reservation table checker.
// Included by the checker file; needs nothing else.
`ifndef INTERVAL_RESERVATION_TABLE_MACROS_SVH
`define INTERVAL_RESERVATION_TABLE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define IRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("interval reservation table check failed");

// Clocked assertion that also holds through reset.
`define IRT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("interval reservation table reset check failed");

`endif

FILE: hdl/irt_pkg.sv
// Shared types and constants for the interval reservation table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

    localparam int IRT_ENTRIES   = 64;
    localparam int IRT_TIME_BITS = 30;

    localparam int IRT_STATUS_W  = 2;
    localparam int IRT_M_DATA_W  = ((IRT_STATUS_W + 7) / 8) * 8;

    localparam logic [IRT_STATUS_W-1:0] STAT_BOOKED   = 2'd0;
    localparam logic [IRT_STATUS_W-1:0] STAT_CONFLICT = 2'd1;
    localparam logic [IRT_STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [IRT_STATUS_W-1:0] STAT_INVALID  = 2'd3;

    // Control from the sequencer to the compare unit.
    typedef struct packed {
        logic clear;  // start of a new request
        logic valid;  // a stored slot is on the data inputs
    } irt_scan_ctl_t;

    // Accumulated compare results.
    typedef struct packed {
        logic conflict;
        logic same;
    } irt_flags_t;

endpackage

`default_nettype wire

FILE: hdl/interval_reservation_table.sv
// Interval reservation table top level: request sequencer, slot memory, result register.
// Depends on irt_pkg and irt_scan.
//
//  channel | dir | fields (tdata, low bit up)            | beat
//  s_      | in  | start_time, end_time, zero pad       | one request
//  m_      | out | status, zero pad                     | one result per request
//
// A request runs from acceptance to the result beat in these steps: one memory read
// per stored slot through the single compare unit, a drain of the read register,
// then a decide step that writes any new slot. An invalid request or an empty table
// goes straight to the decide step. s_tready is low while a request is in progress;
// a pending result in the output register only stalls the decide step. Reset empties
// the table at once (slot contents are not cleared; only slots below the count are read).
`timescale 1ns / 1ps
`default_nettype none

module interval_reservation_table
    import irt_pkg::*;
#(
    parameter int ENTRIES   = IRT_ENTRIES,
    parameter int TIME_BITS = IRT_TIME_BITS,
    localparam int S_DATA_W = ((2 * TIME_BITS + 7) / 8) * 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_DATA_W-1:0]     s_tdata,   // start_time, end_time, zero pad
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [IRT_M_DATA_W-1:0]      m_tdata    // status, zero pad
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int SLOT_W = 2 * TIME_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_DECIDE = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    inv_reg, inv_next;
    logic                    rd_valid_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [IRT_STATUS_W-1:0] m_status_reg, m_status_next;
    logic [TIME_BITS-1:0]    req_start_reg, req_end_reg;
    logic [SLOT_W-1:0]       rd_data_reg;

    logic [SLOT_W-1:0]       slot_mem [ENTRIES];

    logic [TIME_BITS-1:0]    in_start;
    logic [TIME_BITS-1:0]    in_end;
    logic                    s_accept;
    logic                    m_free;
    logic                    last_idx;
    logic                    table_full;
    logic                    rd_en;
    logic                    wr_en;
    irt_scan_ctl_t           scan_ctl;
    irt_flags_t              flags;

    assign in_start   = s_tdata[TIME_BITS-1:0];
    assign in_end     = s_tdata[2*TIME_BITS-1:TIME_BITS];
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid & s_tready;
    assign m_free     = !m_valid_reg || m_tready;
    assign last_idx   = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign table_full = (count_reg == CNT_W'(ENTRIES));

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        inv_next      = inv_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;

        // drop the result beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    inv_next = (in_end < in_start);
                    idx_next = '0;
                    if ((in_end < in_start) || (count_reg == '0)) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold until the output register is free
                if (m_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (inv_reg) begin
                        m_status_next = STAT_INVALID;
                    end else if (flags.conflict) begin
                        m_status_next = STAT_CONFLICT;
                    end else if (flags.same) begin
                        m_status_next = STAT_BOOKED;
                    end else if (table_full) begin
                        m_status_next = STAT_FULL;
                    end else begin
                        m_status_next = STAT_BOOKED;
                        wr_en         = 1'b1;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan_ctl.clear = s_accept;
    assign scan_ctl.valid = rd_valid_reg;

    irt_scan #(
        .TIME_BITS(TIME_BITS)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .req_start (req_start_reg),
        .req_end   (req_end_reg),
        .slot_start(rd_data_reg[TIME_BITS-1:0]),
        .slot_end  (rd_data_reg[SLOT_W-1:TIME_BITS]),
        .flags     (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            count_reg    <= '0;
            inv_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            inv_reg      <= inv_next;
            rd_valid_reg <= rd_en;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_status_reg <= m_status_next;
        if (s_accept) begin
            req_start_reg <= in_start;
            req_end_reg   <= in_end;
        end
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[count_reg[IDX_W-1:0]] <= {req_end_reg, req_start_reg};
        end
        if (rd_en) begin
            rd_data_reg <= slot_mem[idx_reg];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(IRT_M_DATA_W - IRT_STATUS_W){1'b0}}, m_status_reg};

endmodule

`default_nettype wire

FILE: hdl/irt_scan.sv
// Shared overlap/equality compare unit with accumulating flags.
// Depends on irt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irt_scan
    import irt_pkg::*;
#(
    parameter int TIME_BITS = IRT_TIME_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire irt_scan_ctl_t        ctl,
    input  wire logic [TIME_BITS-1:0] req_start,
    input  wire logic [TIME_BITS-1:0] req_end,
    input  wire logic [TIME_BITS-1:0] slot_start,
    input  wire logic [TIME_BITS-1:0] slot_end,
    output irt_flags_t                flags
);

    irt_flags_t flags_reg;
    irt_flags_t flags_next;
    logic       hit_overlap;
    logic       hit_same;

    assign hit_overlap = (slot_start < req_end) && (slot_end > req_start);
    assign hit_same    = (slot_start == req_start) && (slot_end == req_end);

    always_comb begin
        flags_next = flags_reg;
        if (ctl.clear) begin
            flags_next = '0;
        end else if (ctl.valid) begin
            flags_next.conflict = flags_reg.conflict | hit_overlap;
            flags_next.same     = flags_reg.same | hit_same;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

`default_nettype wire

FILE: hdl/irt_checker.sv
// Port-level checks for the interval reservation table, bound to the top level.
// Depends on irt_pkg and interval_reservation_table_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "interval_reservation_table_macros.svh"

module irt_checker
    import irt_pkg::*;
#(
    parameter int TIME_BITS = IRT_TIME_BITS,
    localparam int S_DATA_W = ((2 * TIME_BITS + 7) / 8) * 8
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    s_tvalid,
    input wire logic                    s_tready,
    input wire logic [S_DATA_W-1:0]     s_tdata,   // start_time, end_time, zero pad
    input wire logic                    m_tvalid,
    input wire logic                    m_tready,
    input wire logic [IRT_M_DATA_W-1:0] m_tdata    // status, zero pad
);

    logic [1:0] pend_reg, pend_next;
    logic       s_beat;
    logic       m_beat;
    logic       s_pad_unused;

    assign s_beat       = s_tvalid & s_tready;
    assign m_beat       = m_tvalid & m_tready;
    assign s_pad_unused = ^s_tdata;

    // requests accepted but whose result beat has not gone out yet
    always_comb begin
        pend_next = pend_reg;
        if (s_beat && !m_beat) begin
            pend_next = pend_reg + 2'd1;
        end else if (!s_beat && m_beat) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    `IRT_ASSERT(a_busy_after_accept, aclk, aresetn, s_beat |=> !s_tready)
    `IRT_ASSERT(a_result_has_request, aclk, aresetn, m_tvalid |-> (pend_reg != 2'd0))
    `IRT_ASSERT(a_result_holds, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    `IRT_ASSERT_ALWAYS(a_reset_quiet, aclk, (!aresetn || (s_pad_unused && 1'b0)) |=> !m_tvalid)

endmodule

bind interval_reservation_table irt_checker #(
    .TIME_BITS(TIME_BITS)
) u_irt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

`default_nettype wire
